/* rtl/core/volume_zero_crossing_marker_defines.svh */
// Assertion macros for the zero-crossing marker, empty when SYNTH is defined.
`ifndef VOLUME_ZERO_CROSSING_MARKER_DEFINES_SVH
`define VOLUME_ZERO_CROSSING_MARKER_DEFINES_SVH

`ifndef SYNTH

`define VZC_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define VZC_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define VZC_CHECK(lbl, expr, msg)

`define VZC_CHECK_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/core/vzc_pkg.sv */
// Shared constants and types for the zero-crossing marker.
package vzc_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int OUT_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AXES_USED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_POS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_POS  = 3'd5;

  // One word per in-plane position: bit p holds the class of the plane with parity p.
  localparam int PHASES = 2;
  typedef logic [PHASES-1:0] sign_word_t;

endpackage

/* rtl/core/volume_zero_crossing_marker.sv */
// A result beat passes the stage-0 registers, then the output buffer, after the input beat that releases it.
// A voxel's result is released by the beat size_x*size_y voxels later, or by a pad.
// Throughput: one input beat per cycle while s_tready is high, set by one store access per beat.
// The sign store holds two planes and has one write and four reads per cycle.
// Reset: registers to defaults, positions and backlog cleared; store not cleared.
`include "volume_zero_crossing_marker_defines.svh"

module volume_zero_crossing_marker import vzc_pkg::*; #(
  parameter int MAX_X = 256,
  parameter int MAX_Y = 256,
  parameter int MAX_Z = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [SAMPLE_W-1:0]   s_tdata,   // [31:0] sample
  input  logic                  s_tuser,   // [0] pad
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [0] is_crossing, [7:1] zero
  output logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEPTH = MAX_X * MAX_Y;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(DEPTH + 1);
  localparam int XW    = $clog2(MAX_X + 1);
  localparam int YW    = $clog2(MAX_Y + 1);
  localparam int ZW    = $clog2(MAX_Z + 1);
  localparam int MW    = XW + YW;
  localparam int XIW   = $clog2(MAX_X);
  localparam int YIW   = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
  localparam int ZIW   = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
  localparam int SX_RST  = (MAX_X < 256) ? MAX_X : 256;
  localparam int SY_RST  = (MAX_Y < 256) ? MAX_Y : 256;
  localparam int DXY_RST = SX_RST * SY_RST;
  localparam logic [1:0] CNT_FULL = 2'd3;
  localparam logic [1:0] PTR_LAST = 2'd2;

  typedef struct packed {
    logic par;
    logic xm_en;
    logic xp_en;
    logic ym_en;
    logic yp_en;
    logic zm_en;
    logic zp_en;
    logic zp_cls;
    logic last;
  } s1_t;

  // configuration, sizes held already saturated
  logic [XW-1:0] sx_r;
  logic [YW-1:0] sy_r;
  logic [ZW-1:0] sz_r;
  logic [1:0]    axes_r;
  logic          zpos_r;
  logic          mpos_r;
  logic [PW-1:0] dxy_r;

  logic [XW-1:0] cx_w;
  logic [YW-1:0] cy_w;
  logic [ZW-1:0] cz_w;
  logic [MW-1:0] prod;
  logic          cfg_hit;

  // stream position
  logic [AW-1:0]  w_pp;
  logic           w_par;
  logic [ZIW-1:0] in_z;
  logic [AW-1:0]  o_pp;
  logic           o_par;
  logic [XIW-1:0] o_x;
  logic [YIW-1:0] o_y;
  logic [ZIW-1:0] o_z;
  logic [PW-1:0]  backlog;

  logic       s_fire, pad, cls, rep, in_pos0, w_plane_end;
  logic       x_last, y_last, z_last;
  logic [1:0] dims, axes;

  s1_t        s1;
  logic       s1_valid;
  sign_word_t rd_me, rd_xp, rd_ym, rd_yp;
  logic       me, hit, crossing, last_me;

  logic [1:0] fifo_data [3];
  logic [1:0] wr_ptr, rd_ptr, out_count;
  logic       pop;

  always_comb begin
    cx_w = (cfg_wdata == '0) ? XW'(1) :
           (32'(cfg_wdata) > MAX_X) ? XW'(MAX_X) : XW'(cfg_wdata);
    cy_w = (cfg_wdata == '0) ? YW'(1) :
           (32'(cfg_wdata) > MAX_Y) ? YW'(MAX_Y) : YW'(cfg_wdata);
    cz_w = (cfg_wdata == '0) ? ZW'(1) :
           (32'(cfg_wdata) > MAX_Z) ? ZW'(MAX_Z) : ZW'(cfg_wdata);
    prod = MW'((cfg_index == REG_SIZE_X) ? cx_w : sx_r) *
           MW'((cfg_index == REG_SIZE_Y) ? cy_w : sy_r);
    cfg_hit = cfg_we && (cfg_index <= REG_MARK_POS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sx_r   <= XW'(SX_RST);
      sy_r   <= YW'(SY_RST);
      sz_r   <= ZW'(1);
      axes_r <= 2'd3;
      zpos_r <= 1'b1;
      mpos_r <= 1'b0;
      dxy_r  <= PW'(DXY_RST);
    end else if (cfg_hit) begin
      dxy_r <= PW'(prod);
      unique case (cfg_index)
        REG_SIZE_X:    sx_r   <= cx_w;
        REG_SIZE_Y:    sy_r   <= cy_w;
        REG_SIZE_Z:    sz_r   <= cz_w;
        REG_AXES_USED: axes_r <= cfg_wdata[1:0];
        REG_ZERO_POS:  zpos_r <= cfg_wdata[0];
        REG_MARK_POS:  mpos_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    dims = (sx_r > XW'(1)) ?
           ((sy_r > YW'(1)) ? ((sz_r > ZW'(1)) ? 2'd3 : 2'd2) : 2'd1) : 2'd0;
    axes = (axes_r != 2'd0 && axes_r < dims) ? axes_r : dims;
  end

  assign s_tready = ({1'b0, out_count} + {2'b00, s1_valid}) < {1'b0, CNT_FULL};
  assign s_fire   = s_tvalid && s_tready;
  assign pad      = s_tuser;
  assign cls      = (s_tdata == '0) ? zpos_r : ~s_tdata[SAMPLE_W-1];

  always_comb begin
    in_pos0     = (w_pp == '0) && (in_z == '0);
    w_plane_end = (PW'(w_pp) + PW'(1)) == dxy_r;
    x_last      = (XW'(o_x) + XW'(1)) == sx_r;
    y_last      = (YW'(o_y) + YW'(1)) == sy_r;
    z_last      = (ZW'(o_z) + ZW'(1)) == sz_r;
    rep         = pad ? (backlog != '0 && in_pos0) : (backlog >= dxy_r);
  end

  // stage 0: position bookkeeping, store write and neighbour reads
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      w_pp    <= '0;
      w_par   <= 1'b0;
      in_z    <= '0;
      o_pp    <= '0;
      o_par   <= 1'b0;
      o_x     <= '0;
      o_y     <= '0;
      o_z     <= '0;
      backlog <= '0;
    end else if (s_fire) begin
      if (!pad) begin
        if (w_plane_end) begin
          w_pp  <= '0;
          w_par <= ~w_par;
          in_z  <= ((ZW'(in_z) + ZW'(1)) == sz_r) ? '0 : in_z + 1'b1;
        end else begin
          w_pp <= w_pp + 1'b1;
        end
      end
      if (rep) begin
        o_x <= x_last ? '0 : o_x + 1'b1;
        if (x_last) begin
          o_y <= y_last ? '0 : o_y + 1'b1;
          if (y_last) begin
            o_z <= z_last ? '0 : o_z + 1'b1;
          end
        end
        if (x_last && y_last) begin
          o_pp  <= '0;
          o_par <= ~o_par;
        end else begin
          o_pp <= o_pp + 1'b1;
        end
      end
      priority if (pad && rep) begin
        backlog <= backlog - 1'b1;
      end else if (!pad && !rep) begin
        backlog <= backlog + 1'b1;
      end else begin
        backlog <= backlog;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s_fire && rep && !cfg_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && rep) begin
      s1.par    <= o_par;
      s1.xm_en  <= (axes >= 2'd1) && (o_x != '0);
      s1.xp_en  <= (axes >= 2'd1) && !x_last;
      s1.ym_en  <= (axes >= 2'd2) && (o_y != '0);
      s1.yp_en  <= (axes >= 2'd2) && !y_last;
      s1.zm_en  <= (axes == 2'd3) && (o_z != '0);
      s1.zp_en  <= (axes == 2'd3) && !z_last;
      s1.zp_cls <= cls;
      s1.last   <= x_last && y_last && z_last;
    end
  end

  vzc_sign_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (s_fire && !pad),
    .wa    (w_pp),
    .wbit  (w_par),
    .wd    (cls),
    .re    (s_fire && rep),
    .ra_me (o_pp),
    .ra_xp (o_pp + AW'(1)),
    .ra_ym (o_pp - AW'(sx_r)),
    .ra_yp (o_pp + AW'(sx_r)),
    .rd_me (rd_me),
    .rd_xp (rd_xp),
    .rd_ym (rd_ym),
    .rd_yp (rd_yp)
  );

  // stage 1: compare with neighbours; the left one is the previous voxel's class
  always_comb begin
    me  = rd_me[s1.par];
    hit = (s1.xm_en && (last_me != me))
       || (s1.xp_en && (rd_xp[s1.par] != me))
       || (s1.ym_en && (rd_ym[s1.par] != me))
       || (s1.yp_en && (rd_yp[s1.par] != me))
       || (s1.zm_en && (rd_me[~s1.par] != me))
       || (s1.zp_en && (s1.zp_cls != me));
    crossing = hit && (me == mpos_r);
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      last_me <= me;
    end
  end

  // three-beat output buffer
  assign pop = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      fifo_data[wr_ptr] <= {s1.last, crossing};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      out_count <= '0;
    end else begin
      if (s1_valid) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      out_count <= out_count + {1'b0, s1_valid} - {1'b0, pop};
    end
  end

  assign m_tvalid = (out_count != '0);
  assign m_tdata  = {{(OUT_DATA_W-1){1'b0}}, fifo_data[rd_ptr][0]};
  assign m_tlast  = fifo_data[rd_ptr][1];

  `VZC_CHECK(a_buffer_no_overflow, !(s1_valid && (out_count == CNT_FULL) && !pop), "result buffer overflow")
  `VZC_CHECK(a_backlog_bound, backlog <= dxy_r, "backlog exceeds one plane")
  `VZC_CHECK(a_stall_holds_beat, s_tready || m_tvalid, "input stalled with nothing to deliver")
  `VZC_CHECK_NEXT(a_result_lands, s1_valid, m_tvalid, "computed result not presented")

endmodule

/* rtl/core/vzc_sign_store.sv */
// Two-plane sign store: two identical copies, each with two registered read ports.
module vzc_sign_store import vzc_pkg::*; #(
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic                     wbit,
  input  logic                     wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra_me,
  input  logic [$clog2(DEPTH)-1:0] ra_xp,
  input  logic [$clog2(DEPTH)-1:0] ra_ym,
  input  logic [$clog2(DEPTH)-1:0] ra_yp,
  output sign_word_t               rd_me,
  output sign_word_t               rd_xp,
  output sign_word_t               rd_ym,
  output sign_word_t               rd_yp
);

  sign_word_t mem_a [DEPTH];
  sign_word_t mem_b [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_a[wa][wbit] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_b[wa][wbit] <= wd;
    end
  end

  // Reads see the word as it stood before a write on the same edge.
  always_ff @(posedge clk) begin
    if (re) begin
      rd_me <= mem_a[ra_me];
      rd_xp <= mem_a[ra_xp];
      rd_ym <= mem_b[ra_ym];
      rd_yp <= mem_b[ra_yp];
    end
  end

endmodule
